@@ hdl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the cubic B-spline curve sampler.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int COORD_W     = 16;
    localparam int STEP_W      = 6;
    localparam int MAX_STEPS   = 63;
    localparam int STEPS_RESET = 10;
    localparam int SQ_W        = 12;
    localparam int CUBE_W      = 18;
    localparam int DEN_W       = 21;
    localparam int NUM_W       = 20;

    typedef struct packed {
        logic                      start_curve;
        logic signed [COORD_W-1:0] ctrl_x;
        logic signed [COORD_W-1:0] ctrl_y;
        logic signed [COORD_W-1:0] ctrl_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] curve_x;
        logic signed [COORD_W-1:0] curve_y;
        logic signed [COORD_W-1:0] curve_z;
        logic                      last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } t_lane_ctrl;

endpackage

@@ hdl/bsc_wdiv.sv @@
// ----------------------------------------------------------------------------
// bsc_wdiv
// Iterative weight divider: round(num * 2^FRAC_BITS / den), four quotient
// bits per cycle.
// ----------------------------------------------------------------------------
module bsc_wdiv #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bsc_pkg::NUM_W-1:0] i_num,
    input  logic [bsc_pkg::DEN_W-1:0] i_den,
    output logic [FRAC_BITS:0]        o_weight,
    output logic                      o_done
);

    localparam int QB    = FRAC_BITS + 1;
    localparam int RADIX = 4;
    localparam int ITERS = (QB + RADIX - 1) / RADIX;
    localparam int QBP   = ITERS * RADIX;
    localparam int CNT_W = $clog2(ITERS + 1);
    localparam int DW    = bsc_pkg::DEN_W;

    logic [DW-1:0]    r_rem;
    logic [QBP-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW-1:0]    n_rem;
    logic [QBP-1:0]   n_quo;
    logic [QB:0]      q_round;

    always_comb begin
        logic [DW:0]      rem2;
        logic [DW-1:0]    rem;
        logic [RADIX-1:0] bits;
        rem  = r_rem;
        bits = '0;
        for (int k = 0; k < RADIX; k++) begin
            rem2 = {rem, 1'b0};
            if (rem2 >= {1'b0, i_den}) begin
                bits[RADIX-1-k] = 1'b1;
                rem2 = rem2 - {1'b0, i_den};
            end
            rem = rem2[DW-1:0];
        end
        n_rem = rem;
        n_quo = {r_quo[QBP-RADIX-1:0], bits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITERS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_num);
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // The quotient carries one extra fraction bit; adding one and dropping it
    // rounds half up.
    assign q_round  = {1'b0, r_quo[QBP-1 -: QB]} + (QB + 1)'(1);
    assign o_weight = q_round[QB:1];
    assign o_done   = r_done;

endmodule

@@ hdl/bsc_lane.sv @@
// ----------------------------------------------------------------------------
// bsc_lane
// One coordinate lane: four weighted products, then sum and round.
// ----------------------------------------------------------------------------
module bsc_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  bsc_pkg::t_lane_ctrl                   i_ctrl,
    input  logic [3:0][FRAC_BITS:0]               i_weight,
    input  logic [3:0][bsc_pkg::COORD_W-1:0]      i_point,
    output logic [bsc_pkg::COORD_W-1:0]           o_coord
);

    localparam int CW     = bsc_pkg::COORD_W;
    localparam int PROD_W = FRAC_BITS + 2 + CW;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] r_prod [4];
    logic [CW-1:0]            r_coord;
    logic [ACC_W-1:0]         acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= $signed({1'b0, i_weight[k]}) * $signed(i_point[k]);
            end
        end
        if (i_ctrl.sum_en) begin
            r_coord <= acc[FRAC_BITS +: CW];
        end
    end

    assign acc = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2])
               + ACC_W'(r_prod[3]) + HALF;

    assign o_coord = r_coord;

endmodule

@@ hdl/cubic_bspline_curve_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// cubic_bspline_curve_sampler_unit
// Uniform cubic B-spline sampler over a sliding window of control points.
//
//   Channel   Direction  Handshake                   Payload
//   in        input      i_in_valid / o_in_ready     i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_ready   o_out_item (t_out_item)
//   cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_data (steps, 6 bits)
//
// An item that closes no window only updates the window. An item that closes a
// window passes S_CUBE1 and S_CUBE2, then for each sample S_STEP (skipped when
// the t = 0 sample leads), S_LOAD, S_DIV, S_WSUM, S_MUL, S_SUM and S_OUT; the
// time spent in S_DIV is set by the weight dividers.
// Items are handled one at a time; a full output register stalls the sampler.
// Reset is synchronous and sets the step count to 10 and empties the window.
// ----------------------------------------------------------------------------
module cubic_bspline_curve_sampler_unit #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  bsc_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output bsc_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bsc_pkg::STEP_W-1:0] i_cfg_data
);

    localparam int CW   = bsc_pkg::COORD_W;
    localparam int SW   = bsc_pkg::STEP_W;
    localparam int QW   = bsc_pkg::SQ_W;
    localparam int TW   = bsc_pkg::CUBE_W;
    localparam int DW   = bsc_pkg::DEN_W;
    localparam int NW   = bsc_pkg::NUM_W;
    localparam int WW   = WEIGHT_FRAC_BITS + 1;
    localparam int N1_W = DW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CUBE1, S_CUBE2, S_STEP, S_LOAD, S_DIV, S_WSUM, S_MUL, S_SUM, S_OUT
    } t_state;

    t_state             r_state;
    logic [SW-1:0]      r_steps;
    logic [1:0]         r_seen;
    logic               r_first_done;
    bsc_pkg::t_point    r_win [3];
    logic               r_out_valid;
    bsc_pkg::t_out_item r_out;

    bsc_pkg::t_point    r_pt;
    logic [SW-1:0]      r_s;
    logic [QW-1:0]      r_s2;
    logic [TW-1:0]      r_s3;
    logic [DW-1:0]      r_den;
    logic [SW-1:0]      r_j;
    logic [QW-1:0]      r_j2;
    logic [TW-1:0]      r_j3;
    logic [QW-1:0]      r_js;
    logic [TW-1:0]      r_js2;
    logic [SW-1:0]      r_d;
    logic [QW-1:0]      r_d2;
    logic [TW-1:0]      r_d3;
    logic [3:0][WW-1:0] r_w;

    logic               in_accept;
    logic               out_free;
    logic               emit;
    logic [SW-1:0]      s_eff;
    logic [TW-1:0]      s3;
    logic [N1_W-1:0]    num1;
    logic               div_start;
    logic [2:0][NW-1:0] div_num;
    logic [2:0][WW-1:0] div_w;
    logic [2:0]         div_done;
    logic [WW-1:0]      w2;
    bsc_pkg::t_lane_ctrl             lane_ctrl;
    logic [2:0][3:0][CW-1:0]         lane_pt;
    logic [2:0][CW-1:0]              lane_coord;
    bsc_pkg::t_point                 new_pt;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign emit        = !i_in_item.start_curve && (r_seen == 2'd3);

    assign new_pt = '{x: i_in_item.ctrl_x, y: i_in_item.ctrl_y, z: i_in_item.ctrl_z};

    always_comb begin
        if (r_steps == '0) begin
            s_eff = SW'(1);
        end else if (r_steps > SW'(bsc_pkg::MAX_STEPS)) begin
            s_eff = SW'(bsc_pkg::MAX_STEPS);
        end else begin
            s_eff = r_steps;
        end
    end

    assign s3   = TW'(r_s2) * TW'(r_s);
    assign num1 = N1_W'(4 * r_s3) + N1_W'(3 * r_j3) - N1_W'(6 * r_js2);

    assign div_start  = (r_state == S_LOAD);
    assign div_num[0] = NW'(r_d3);
    assign div_num[1] = num1[NW-1:0];
    assign div_num[2] = NW'(r_j3);

    for (genvar g = 0; g < 3; g++) begin : g_div
        bsc_wdiv #(
            .FRAC_BITS (WEIGHT_FRAC_BITS)
        ) u_wdiv (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (div_start),
            .i_num    (div_num[g]),
            .i_den    (r_den),
            .o_weight (div_w[g]),
            .o_done   (div_done[g])
        );
    end

    assign w2 = (WW'(1) << WEIGHT_FRAC_BITS) - div_w[0] - div_w[1] - div_w[2];

    assign lane_ctrl = '{mul_en: (r_state == S_MUL), sum_en: (r_state == S_SUM)};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lane_pt[0][k] = r_win[k].x;
            lane_pt[1][k] = r_win[k].y;
            lane_pt[2][k] = r_win[k].z;
        end
        lane_pt[0][3] = r_pt.x;
        lane_pt[1][3] = r_pt.y;
        lane_pt[2][3] = r_pt.z;
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        bsc_lane #(
            .FRAC_BITS (WEIGHT_FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (lane_ctrl),
            .i_weight (r_w),
            .i_point  (lane_pt[g]),
            .o_coord  (lane_coord[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_steps      <= SW'(bsc_pkg::STEPS_RESET);
            r_seen       <= '0;
            r_first_done <= 1'b0;
            r_win        <= '{default: '0};
            r_out_valid  <= 1'b0;
            r_out        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_steps <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (emit) begin
                            r_state <= S_CUBE1;
                        end else if (i_in_item.start_curve) begin
                            r_win        <= '{'0, '0, new_pt};
                            r_seen       <= 2'd1;
                            r_first_done <= 1'b0;
                        end else begin
                            r_win  <= '{r_win[1], r_win[2], new_pt};
                            r_seen <= r_seen + 2'd1;
                        end
                    end
                end
                S_CUBE1: r_state <= S_CUBE2;
                S_CUBE2: r_state <= r_first_done ? S_STEP : S_LOAD;
                S_STEP:  r_state <= S_LOAD;
                S_LOAD:  r_state <= S_DIV;
                S_DIV: begin
                    if (div_done[0]) begin
                        r_state <= S_WSUM;
                    end
                end
                S_WSUM: r_state <= S_MUL;
                S_MUL:  r_state <= S_SUM;
                S_SUM:  r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out        <= '{curve_x: lane_coord[0], curve_y: lane_coord[1],
                                          curve_z: lane_coord[2], last_of_run: (r_j == r_s)};
                        r_first_done <= 1'b1;
                        if (r_j == r_s) begin
                            r_win   <= '{r_win[1], r_win[2], r_pt};
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_STEP;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pt <= new_pt;
            r_s  <= s_eff;
        end
        if (r_state == S_CUBE1) begin
            r_s2 <= QW'(r_s) * QW'(r_s);
        end
        if (r_state == S_CUBE2) begin
            r_s3  <= s3;
            r_den <= DW'(6 * s3);
            r_j   <= '0;
            r_j2  <= '0;
            r_j3  <= '0;
            r_js  <= '0;
            r_js2 <= '0;
            r_d   <= r_s;
            r_d2  <= r_s2;
            r_d3  <= s3;
        end
        if (r_state == S_STEP) begin
            r_j   <= r_j + SW'(1);
            r_j2  <= r_j2 + QW'(2 * r_j) + QW'(1);
            r_j3  <= r_j3 + TW'(3 * r_j2) + TW'(3 * r_j) + TW'(1);
            r_js  <= r_js + QW'(r_s);
            r_js2 <= r_js2 + TW'(2 * r_js) + TW'(r_s);
            r_d   <= r_d - SW'(1);
            r_d2  <= r_d2 - QW'(2 * r_d) + QW'(1);
            r_d3  <= r_d3 - TW'(3 * r_d2) + TW'(3 * r_d) - TW'(1);
        end
        if (r_state == S_WSUM) begin
            r_w <= {div_w[2], w2, div_w[1], div_w[0]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_div_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_done[0] == div_done[1]) && (div_done[0] == div_done[2]))
        else $error("weight dividers finished out of step");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done[0] |-> (r_state == S_DIV))
        else $error("weight divider finished outside the wait state");

    a_window_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CUBE1) |-> (r_seen == 2'd3))
        else $error("sampling started without a full window");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free && r_j == r_s) |=> (r_state == S_IDLE && o_out_valid
                                                         && o_out_item.last_of_run))
        else $error("last sample did not end the item");

    a_sample_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> o_out_valid)
        else $error("sample was not presented");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cubic B-spline curve sampler. Control points are
// sent as directed curves and then as random curves under several step
// counts and idle patterns. Each accepted item is run through an in-bench
// fixed-point model of the sampler, and the curve samples it predicts are
// compared in order with the samples that the block hands out.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WFRAC      = 16;
    localparam int LIMIT      = 3_000_000;
    localparam int SETTLE     = 8;
    localparam int TAIL       = 3 + (bsc_pkg::MAX_STEPS + 1) * (7 + (WFRAC + 4) / 4) + 100;
    localparam int SHOW_ERRS  = 10;
    localparam int CW         = bsc_pkg::COORD_W;
    localparam int SW         = bsc_pkg::STEP_W;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    class t_sample_board;
        int unsigned        steps;
        longint             win [3][3];
        int unsigned        filled;
        bit                 lead_done;
        bsc_pkg::t_out_item pending_samples [$];
        int unsigned        failures;

        function new();
            steps = bsc_pkg::STEPS_RESET;
            failures = 0;
            clear_window();
        endfunction

        function void clear_window();
            int a;
            int k;
            for (a = 0; a < 3; a++) begin
                for (k = 0; k < 3; k++) begin
                    win[a][k] = 0;
                end
            end
            filled = 0;
            lead_done = 0;
        endfunction

        function longint q_weight(longint num, longint den);
            return ((num <<< WFRAC) + den / 2) / den;
        endfunction

        function void push_sample(longint j, longint s, longint p [3], bit last);
            longint w [4];
            longint den;
            longint acc;
            longint rounded;
            logic signed [CW-1:0] c [3];
            bsc_pkg::t_out_item smp;
            int a;
            den = 6 * s * s * s;
            w[0] = q_weight((s - j) * (s - j) * (s - j), den);
            w[1] = q_weight(3 * j * j * j - 6 * j * j * s + 4 * s * s * s, den);
            w[3] = q_weight(j * j * j, den);
            w[2] = (longint'(1) <<< WFRAC) - w[0] - w[1] - w[3];
            for (a = 0; a < 3; a++) begin
                acc = w[0] * win[a][0] + w[1] * win[a][1] + w[2] * win[a][2] + w[3] * p[a];
                rounded = (acc + (longint'(1) <<< (WFRAC - 1))) >>> WFRAC;
                c[a] = rounded[CW-1:0];
            end
            smp.curve_x = c[0];
            smp.curve_y = c[1];
            smp.curve_z = c[2];
            smp.last_of_run = last;
            pending_samples = {pending_samples, smp};
        endfunction

        function void take_point(bsc_pkg::t_in_item it);
            longint p [3];
            longint s;
            longint j;
            int a;
            p[0] = longint'($signed(it.ctrl_x));
            p[1] = longint'($signed(it.ctrl_y));
            p[2] = longint'($signed(it.ctrl_z));
            if (it.start_curve) begin
                clear_window();
            end
            if (filled >= 3) begin
                s = (steps == 0) ? 1 : steps;
                if (s > bsc_pkg::MAX_STEPS) begin
                    s = bsc_pkg::MAX_STEPS;
                end
                if (!lead_done) begin
                    push_sample(0, s, p, 1'b0);
                    lead_done = 1;
                end
                for (j = 1; j <= s; j++) begin
                    push_sample(j, s, p, j == s);
                end
            end
            for (a = 0; a < 3; a++) begin
                win[a][0] = win[a][1];
                win[a][1] = win[a][2];
                win[a][2] = p[a];
            end
            if (filled < 3) begin
                filled++;
            end
        endfunction

        function void check_sample(bsc_pkg::t_out_item got);
            bsc_pkg::t_out_item want;
            if (pending_samples.size() == 0) begin
                failures++;
                if (failures <= SHOW_ERRS) begin
                    $display("unexpected sample (%0d, %0d, %0d, last %0b)",
                             got.curve_x, got.curve_y, got.curve_z, got.last_of_run);
                end
            end else begin
                want = pending_samples.pop_front();
                if (got.curve_x !== want.curve_x || got.curve_y !== want.curve_y ||
                    got.curve_z !== want.curve_z || got.last_of_run !== want.last_of_run) begin
                    failures++;
                    if (failures <= SHOW_ERRS) begin
                        $display({"sample mismatch: expected (%0d, %0d, %0d, last %0b), ",
                                  "got (%0d, %0d, %0d, last %0b)"},
                                 want.curve_x, want.curve_y, want.curve_z, want.last_of_run,
                                 got.curve_x, got.curve_y, got.curve_z, got.last_of_run);
                    end
                end
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    bsc_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    bsc_pkg::t_out_item o_out_item;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [SW-1:0]      i_cfg_data  = '0;

    t_sample_board board = new();
    int            in_idle_pct   = 0;
    int            out_stall_pct = 0;
    int            cycle_count   = 0;

    cubic_bspline_curve_sampler_unit #(
        .WEIGHT_FRAC_BITS(WFRAC)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            board.check_sample(o_out_item);
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(15))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return '1;
            default: return CW'($urandom());
        endcase
    endfunction

    task automatic send_point(input bit start, input logic signed [CW-1:0] x,
                              input logic signed [CW-1:0] y,
                              input logic signed [CW-1:0] z);
        bsc_pkg::t_in_item it;
        it.start_curve = start;
        it.ctrl_x = x;
        it.ctrl_y = y;
        it.ctrl_z = z;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        board.take_point(it);
    endtask

    task automatic set_steps(input logic [SW-1:0] v);
        i_in_valid <= 1'b0;
        while (board.pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.steps = v;
    endtask

    task automatic run_curves(input int n);
        int sent;
        int len;
        int k;
        bit start;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 85) begin
                len = $urandom_range(4, 14);
            end else begin
                len = $urandom_range(1, 3);
            end
            for (k = 0; k < len && sent < n; k++) begin
                if (k == 0) begin
                    start = ($urandom_range(9) != 0);
                end else begin
                    start = ($urandom_range(29) == 0);
                end
                send_point(start, rand_coord(), rand_coord(), rand_coord());
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [SW-1:0] steps, input int in_pct,
                             input int out_pct, input int n);
        set_steps(steps);
        in_idle_pct = in_pct;
        out_stall_pct = out_pct;
        run_curves(n);
    endtask

    initial begin
        int k;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first curve after reset carries no start flag.
        send_point(1'b0, C_MAX, C_MIN, '0);
        send_point(1'b0, C_MIN, C_MAX, '1);
        send_point(1'b0, C_MAX, C_MAX, C_MAX);
        send_point(1'b0, C_MIN, C_MIN, C_MIN);
        send_point(1'b0, 16'sd1234, -16'sd77, 16'sd5);

        // A curve of three points emits no samples.
        send_point(1'b1, C_MIN, 16'sd100, C_MAX);
        send_point(1'b0, 16'sd3, C_MAX, C_MIN);
        send_point(1'b0, -16'sd9, 16'sd0, 16'sd42);

        for (k = 0; k < 4; k++) begin
            send_point(k == 0, C_MAX, C_MAX, C_MAX);
        end
        for (k = 0; k < 4; k++) begin
            send_point(k == 0, C_MIN, C_MIN, C_MIN);
        end

        // A step count of zero acts as one.
        set_steps('0);
        for (k = 0; k < 5; k++) begin
            send_point(k == 0, rand_coord(), rand_coord(), rand_coord());
        end

        set_steps(SW'(bsc_pkg::MAX_STEPS));
        for (k = 0; k < 4; k++) begin
            send_point(k == 0, rand_coord(), rand_coord(), rand_coord());
        end

        run_phase(SW'($urandom_range(2, 6)), 0, 0, 70);
        run_phase(SW'(1), 46, 0, 70);
        run_phase(SW'($urandom_range(3, 12)), 0, 46, 70);
        run_phase(SW'(bsc_pkg::MAX_STEPS), 17, 17, 12);
        run_phase(SW'($urandom_range(0, 8)), 17, 17, 70);
        run_phase(SW'($urandom_range(1, 20)), 0, 0, 50);

        i_in_valid <= 1'b0;
        while (board.pending_samples.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
